[hw/rtl/pcd_pkg.sv]
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the percent decoder
// Character codes, escape phase encoding, status codes and the
// classification record that the character classifier hands to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  // Characters that the decoder treats specially.
  localparam logic [7:0] CharPercent = 8'h25;  // '%'
  localparam logic [7:0] CharDigit0  = 8'h30;  // '0'
  localparam logic [7:0] CharDigit9  = 8'h39;  // '9'
  localparam logic [7:0] CharLowerA  = 8'h61;  // 'a'
  localparam logic [7:0] CharLowerF  = 8'h66;  // 'f'
  localparam logic [7:0] CharLowerZ  = 8'h7A;  // 'z'
  localparam logic [7:0] CharUpperA  = 8'h41;  // 'A'
  localparam logic [7:0] CharUpperF  = 8'h46;  // 'F'
  localparam logic [7:0] CharUpperZ  = 8'h5A;  // 'Z'
  localparam logic [7:0] CharHyphen  = 8'h2D;  // '-'
  localparam logic [7:0] CharDot     = 8'h2E;  // '.'
  localparam logic [7:0] CharUnder   = 8'h5F;  // '_'
  localparam logic [7:0] CharTilde   = 8'h7E;  // '~'

  // Offset added to a letter digit to give its hex value.
  localparam logic [7:0] HexLetterBase = 8'd10;

  // Result status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusForbidden = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;

  // Escape phase, one-hot.
  typedef enum logic [3:0] {
    PhNormal = 4'b0001,
    PhHigh   = 4'b0010,
    PhLow    = 4'b0100,
    PhDrop   = 4'b1000
  } phase_e;

  // What the classifier knows about one character.
  typedef struct packed {
    logic       is_percent;
    logic       passes;
    logic [3:0] hex_value;
  } char_class_t;

endpackage

`default_nettype wire

[hw/rtl/pcd_classify.sv]
// ----------------------------------------------------------------------------
// pcd_classify: character classifier
// Gives the hex digit value of a character (zero when it is not a hex digit),
// and flags the percent sign and the characters that pass through unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcd_classify (
  input  wire logic [7:0]          char_i,
  output pcd_pkg::char_class_t     class_o
);

  logic [7:0] diff_digit;
  logic [7:0] diff_lower;
  logic [7:0] diff_upper;

  assign diff_digit = char_i - pcd_pkg::CharDigit0;
  assign diff_lower = char_i - pcd_pkg::CharLowerA + pcd_pkg::HexLetterBase;
  assign diff_upper = char_i - pcd_pkg::CharUpperA + pcd_pkg::HexLetterBase;

  always_comb begin
    class_o.is_percent = (char_i == pcd_pkg::CharPercent);

    unique case (char_i) inside
      [pcd_pkg::CharDigit0 : pcd_pkg::CharDigit9]: class_o.hex_value = diff_digit[3:0];
      [pcd_pkg::CharLowerA : pcd_pkg::CharLowerF]: class_o.hex_value = diff_lower[3:0];
      [pcd_pkg::CharUpperA : pcd_pkg::CharUpperF]: class_o.hex_value = diff_upper[3:0];
      default:                                    class_o.hex_value = 4'd0;
    endcase

    // Unreserved characters first, then the reserved set.
    unique case (char_i) inside
      [pcd_pkg::CharDigit0 : pcd_pkg::CharDigit9],
      [pcd_pkg::CharLowerA : pcd_pkg::CharLowerZ],
      [pcd_pkg::CharUpperA : pcd_pkg::CharUpperZ],
      pcd_pkg::CharHyphen, pcd_pkg::CharDot, pcd_pkg::CharUnder, pcd_pkg::CharTilde,
      ":", "/", "?", "#", "[", "]", "@",
      "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=": class_o.passes = 1'b1;
      default:                                              class_o.passes = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/percent_decoder_core.sv]
// ----------------------------------------------------------------------------
// percent_decoder_core: streaming URI percent decoder
// An accepted item waits in the input register and is processed once the
// result register is free. Throughput: one item per cycle, sustained while
// the output side takes items. The rate is set by the input register and the
// result register around a single pass of classification and escape-state logic.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// escape phase to normal with a zero high nibble.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input channel.
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            message_end_o,
  output logic [1:0]      status_o
);

  // Input register. The payload needs no reset; only the valid flag does.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Escape state.
  pcd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      nibble_q, nibble_d;

  // Result register.
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       byte_valid_q;
  logic       message_end_q;
  logic [1:0] status_q;

  // Result of the current pass.
  logic       emit;
  logic [7:0] res_byte;
  logic       res_valid;
  logic       res_end;
  logic [1:0] res_status;

  logic advance;
  pcd_pkg::char_class_t char_class;

  // The held item is processed once the result register is free or being
  // emptied in this cycle. Items that give no result are consumed without
  // writing it, but they wait for it as well and so can stall too.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  pcd_classify u_classify (
    .char_i  (in_byte_q),
    .class_o (char_class)
  );

  // Escape sequencer. A percent sign opens an escape; the next two bytes are
  // taken as digits whatever they are. A forbidden character closes the
  // message early and the rest of it is dropped up to its last byte.
  always_comb begin
    phase_d    = phase_q;
    nibble_d   = nibble_q;
    emit       = 1'b0;
    res_byte   = 8'd0;
    res_valid  = 1'b0;
    res_end    = 1'b1;
    res_status = pcd_pkg::StatusOk;

    unique case (phase_q)
      pcd_pkg::PhHigh: begin
        nibble_d = char_class.hex_value;
        if (in_last_q) begin
          // The message ended on the high digit.
          emit       = 1'b1;
          res_status = pcd_pkg::StatusTruncated;
          phase_d    = pcd_pkg::PhNormal;
        end else begin
          phase_d = pcd_pkg::PhLow;
        end
      end
      pcd_pkg::PhLow: begin
        emit      = 1'b1;
        res_byte  = {nibble_q, char_class.hex_value};
        res_valid = 1'b1;
        res_end   = in_last_q;
        phase_d   = pcd_pkg::PhNormal;
      end
      pcd_pkg::PhDrop: begin
        if (in_last_q) begin
          phase_d = pcd_pkg::PhNormal;
        end
      end
      pcd_pkg::PhNormal: begin
        if (char_class.is_percent) begin
          if (in_last_q) begin
            // The message ended on the percent sign itself.
            emit       = 1'b1;
            res_status = pcd_pkg::StatusTruncated;
          end else begin
            phase_d = pcd_pkg::PhHigh;
          end
        end else if (char_class.passes) begin
          emit      = 1'b1;
          res_byte  = in_byte_q;
          res_valid = 1'b1;
          res_end   = in_last_q;
        end else begin
          emit       = 1'b1;
          res_status = pcd_pkg::StatusForbidden;
          phase_d    = in_last_q ? pcd_pkg::PhNormal : pcd_pkg::PhDrop;
        end
      end
      default: begin
        phase_d = pcd_pkg::PhNormal;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= pcd_pkg::PhNormal;
      nibble_q    <= 4'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q  <= phase_d;
        nibble_q <= nibble_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (advance && emit) begin
      out_byte_q    <= res_byte;
      byte_valid_q  <= res_valid;
      message_end_q <= res_end;
      status_q      <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign message_end_o = message_end_q;
  assign status_o      = status_q;

  // A decoded or passed character always carries the ok status.
  a_valid_byte_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && byte_valid_q |-> status_q == pcd_pkg::StatusOk)
    else $error("decoded item carries an error status");

  // An item without a character is an error and always ends the message.
  a_error_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !byte_valid_q |->
      message_end_q && out_byte_q == 8'd0 && status_q != pcd_pkg::StatusOk)
    else $error("error item does not close the message");

  // A forbidden character in mid-message puts the block into dropping.
  a_drop_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == pcd_pkg::PhNormal && !char_class.is_percent &&
      !char_class.passes && !in_last_q |=> phase_q == pcd_pkg::PhDrop)
    else $error("forbidden character did not start dropping");

  // While dropping, the block produces no result.
  a_drop_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == pcd_pkg::PhDrop |-> !emit)
    else $error("result produced while dropping");

endmodule

`default_nettype wire

[tb/sv/percent_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// percent_decoder_core_tb: self-checking bench for the streaming URI decoder
// Sends directed and random percent-encoded messages one item at a time and
// predicts every result with a behavioural copy of the escape state machine.
// Both channels idle in random bursts, and each result is checked field by
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module percent_decoder_core_tb;

  localparam int  MaxReported   = 10;
  localparam int  RandomItems   = 1925;
  localparam int  QuietTail     = 300;
  localparam int  DrainLimit    = 5000;
  localparam int  SettleCycles  = 8;
  localparam real RunLimitNs    = 5_000_000.0;

  // One result as the core presents it on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       message_end;
    logic [1:0] status;
  } decode_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       message_end_o;
  logic [1:0] status_o;

  // Random idling is switched off for the final stretch of the run.
  bit idling_on = 1'b1;
  int items_sent;
  int messages_sent;

  always #6 clk_i = ~clk_i;

  percent_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .message_end_o (message_end_o),
    .status_o      (status_o)
  );

  // Unreserved and reserved URI characters pass straight through the core.
  function automatic bit is_uri_char(logic [7:0] c);
    if (c >= pcd_pkg::CharDigit0 && c <= pcd_pkg::CharDigit9) return 1'b1;
    if (c >= pcd_pkg::CharLowerA && c <= pcd_pkg::CharLowerZ) return 1'b1;
    if (c >= pcd_pkg::CharUpperA && c <= pcd_pkg::CharUpperZ) return 1'b1;
    case (c)
      pcd_pkg::CharHyphen, pcd_pkg::CharDot, pcd_pkg::CharUnder, pcd_pkg::CharTilde,
      ":", "/", "?", "#", "[", "]", "@",
      "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Picks one of the 22 characters that are valid hex digits.
  function automatic logic [7:0] random_hex_char();
    int idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return 8'(pcd_pkg::CharDigit0 + idx);
    if (idx < 16) return 8'(pcd_pkg::CharLowerA + idx - 10);
    return 8'(pcd_pkg::CharUpperA + idx - 16);
  endfunction

  // Holds the predicted escape state and the queue of results still owed.
  class decoder_scoreboard;
    pcd_pkg::phase_e phase;
    logic [3:0]      high_nibble;
    decode_result_t  due_results[$];
    int              mismatches;
    int              results_checked;
    int              truncations;
    int              forbidden_hits;

    function new();
      phase           = pcd_pkg::PhNormal;
      high_nibble     = 4'h0;
      mismatches      = 0;
      results_checked = 0;
      truncations     = 0;
      forbidden_hits  = 0;
    endfunction

    // A byte outside the hex alphabet is read as a zero digit.
    function logic [3:0] digit_value(logic [7:0] c);
      if (c >= pcd_pkg::CharDigit0 && c <= pcd_pkg::CharDigit9)
        return 4'(c - pcd_pkg::CharDigit0);
      if (c >= pcd_pkg::CharLowerA && c <= pcd_pkg::CharLowerF)
        return 4'(c - pcd_pkg::CharLowerA + pcd_pkg::HexLetterBase);
      if (c >= pcd_pkg::CharUpperA && c <= pcd_pkg::CharUpperF)
        return 4'(c - pcd_pkg::CharUpperA + pcd_pkg::HexLetterBase);
      return 4'h0;
    endfunction

    // Advances the predicted state by one accepted item and queues any result.
    function void take_char(logic [7:0] c, logic last);
      decode_result_t r;
      bit             owed;
      r    = '0;
      owed = 1'b0;
      case (phase)
        pcd_pkg::PhHigh: begin
          high_nibble = digit_value(c);
          if (last) begin
            phase   = pcd_pkg::PhNormal;
            owed    = 1'b1;
            r.message_end = 1'b1;
            r.status      = pcd_pkg::StatusTruncated;
          end else begin
            phase = pcd_pkg::PhLow;
          end
        end
        pcd_pkg::PhLow: begin
          phase = pcd_pkg::PhNormal;
          owed  = 1'b1;
          r.out_byte    = {high_nibble, digit_value(c)};
          r.byte_valid  = 1'b1;
          r.message_end = last;
          r.status      = pcd_pkg::StatusOk;
        end
        pcd_pkg::PhDrop: begin
          if (last) phase = pcd_pkg::PhNormal;
        end
        default: begin
          owed = 1'b1;
          if (c == pcd_pkg::CharPercent) begin
            if (last) begin
              phase = pcd_pkg::PhNormal;
              r.message_end = 1'b1;
              r.status      = pcd_pkg::StatusTruncated;
            end else begin
              phase = pcd_pkg::PhHigh;
              owed  = 1'b0;
            end
          end else if (is_uri_char(c)) begin
            phase = pcd_pkg::PhNormal;
            r.out_byte    = c;
            r.byte_valid  = 1'b1;
            r.message_end = last;
            r.status      = pcd_pkg::StatusOk;
          end else begin
            phase = last ? pcd_pkg::PhNormal : pcd_pkg::PhDrop;
            r.message_end = 1'b1;
            r.status      = pcd_pkg::StatusForbidden;
          end
        end
      endcase
      if (owed) due_results.push_back(r);
    endfunction

    function void check_decode(decode_result_t got);
      decode_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: unexpected result out_byte %h byte_valid %b message_end %b status %0d",
                   $realtime, got.out_byte, got.byte_valid, got.message_end, got.status);
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      if (want.status == pcd_pkg::StatusTruncated) truncations++;
      if (want.status == pcd_pkg::StatusForbidden) forbidden_hits++;
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.message_end !== want.message_end || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: mismatch, expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                   $realtime, want.out_byte, want.byte_valid, want.message_end,
                   want.status, got.out_byte, got.byte_valid, got.message_end,
                   got.status);
      end
    endfunction
  endclass

  decoder_scoreboard sb = new();

  // Presents one item at a falling edge and holds it until the core takes it.
  // The task returns at a falling edge with valid still high, so a following
  // item simply replaces the payload; a random gap lowers valid instead.
  task automatic send_item(logic [7:0] c, logic last);
    in_valid_i  = 1'b1;
    data_byte_i = c;
    last_byte_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_char(c, last);
    items_sent++;
    if (last) messages_sent++;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic wait_for_drain();
    in_valid_i = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
  endtask

  // The directed part walks through pass-through characters, good escapes,
  // escapes with non-hex digits, cut-short escapes and forbidden bytes both
  // in the middle of a message and on its last byte.
  task automatic send_directed();
    // Pass-through at the edges of the letter and reserved sets.
    send_item(pcd_pkg::CharTilde, 1'b0);
    send_item(pcd_pkg::CharLowerZ, 1'b0);
    send_item(pcd_pkg::CharUpperZ, 1'b0);
    send_item(":", 1'b1);
    // A plain escape that ends the message on its low digit.
    send_item(pcd_pkg::CharPercent, 1'b0);
    send_item("4", 1'b0);
    send_item("1", 1'b1);
    // Mixed-case hex digits, and a percent sign read as a zero digit.
    send_item(pcd_pkg::CharPercent, 1'b0);
    send_item(pcd_pkg::CharLowerF, 1'b0);
    send_item(pcd_pkg::CharUpperF, 1'b0);
    send_item(pcd_pkg::CharPercent, 1'b0);
    send_item(pcd_pkg::CharPercent, 1'b0);
    send_item(pcd_pkg::CharDigit9, 1'b1);
    // Messages that end on the escape head and on the high digit.
    send_item(pcd_pkg::CharPercent, 1'b1);
    send_item(pcd_pkg::CharPercent, 1'b0);
    send_item(pcd_pkg::CharLowerA, 1'b1);
    // Non-hex digits count as zero.
    send_item(pcd_pkg::CharPercent, 1'b0);
    send_item("g", 1'b0);
    send_item(pcd_pkg::CharUpperZ, 1'b1);
    // A forbidden byte mid-message, after which the rest is dropped.
    send_item(8'hFF, 1'b0);
    send_item(pcd_pkg::CharLowerA, 1'b0);
    send_item(pcd_pkg::CharPercent, 1'b1);
    // Forbidden bytes on the last position.
    send_item(8'h00, 1'b1);
    send_item(pcd_pkg::CharDot, 1'b0);
    send_item(8'h20, 1'b1);
  endtask

  // Random messages: mostly well-formed text with escapes, plus raw noise,
  // messages cut short inside an escape and messages with a forbidden byte.
  task automatic send_random();
    logic [7:0] msg[$];
    logic [7:0] c;
    int         mode;
    int         len;
    bit         drained;
    drained = 1'b0;
    while (items_sent < RandomItems) begin
      if (items_sent > RandomItems - QuietTail) idling_on = 1'b0;
      // Halfway through, let the core empty completely before going on.
      if (!drained && items_sent > RandomItems / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
      mode = $urandom_range(0, 9);
      len  = $urandom_range(1, 12);
      msg.delete();
      if (mode == 7) begin
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        while (msg.size() < len) begin
          if ($urandom_range(0, 3) == 0) begin
            msg.push_back(pcd_pkg::CharPercent);
            msg.push_back(random_hex_char());
            msg.push_back(random_hex_char());
          end else begin
            do c = 8'($urandom_range(0, 255)); while (!is_uri_char(c));
            msg.push_back(c);
          end
        end
        if (mode == 8) begin
          msg.push_back(pcd_pkg::CharPercent);
          if ($urandom_range(0, 1) == 1) msg.push_back(random_hex_char());
        end
        if (mode == 9) begin
          do c = 8'($urandom_range(0, 255));
          while (is_uri_char(c) || c == pcd_pkg::CharPercent);
          msg.insert($urandom_range(0, msg.size() - 1), c);
        end
      end
      foreach (msg[i]) send_item(msg[i], i == msg.size() - 1);
    end
  endtask

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin : ready_driver
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ready_i = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Results are sampled at the rising edge at which the handshake completes.
  initial begin : result_monitor
    decode_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.out_byte    = out_byte_o;
        got.byte_valid  = byte_valid_o;
        got.message_end = message_end_o;
        got.status      = status_o;
        sb.check_decode(got);
      end
    end
  end

  initial begin : main_sequence
    int waited;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    last_byte_i   = 1'b0;
    items_sent    = 0;
    messages_sent = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    send_directed();
    send_random();
    in_valid_i = 1'b0;

    // Let the pipeline drain, then give it a few more cycles so that any
    // stray extra result would still be seen.
    waited = 0;
    while (sb.due_results.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);

    if (sb.due_results.size() != 0)
      $display("%0d predicted results never arrived", sb.due_results.size());
    $display("Sent %0d items in %0d messages; checked %0d results.",
             items_sent, messages_sent, sb.results_checked);
    $display("Of those, %0d were cut-short escapes and %0d forbidden bytes; %0d mismatches.",
             sb.truncations, sb.forbidden_hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("percent_decoder_core_tb: done, clean");
    end else begin
      $display("percent_decoder_core_tb: done, errors");
    end
    $finish;
  end

  // Safety net in case a handshake never completes.
  initial begin : watchdog
    #(RunLimitNs);
    $display("Run limit reached with %0d items sent.", items_sent);
    $display("percent_decoder_core_tb: done, errors");
    $finish;
  end

endmodule
